// ===== rtl/core/fmps_pkg.sv =====
package fmps_pkg;

   localparam int SKIP_COUNT_DEF  = 15;
   localparam int COUNT_WIDTH_DEF = 12;

   localparam int SAMPLE_W = 24;
   localparam int DEADBAND_W = 23;
   localparam int SCOUNT_W = 12;
   localparam int COEF_W = 64;
   localparam int WEIGHT_W = 32;
   localparam int NUM_COEF = 6;

   localparam logic [DEADBAND_W-1:0] DEADBAND_RST = 23'd3;
   localparam logic [SCOUNT_W-1:0]   SCOUNT_RST   = 12'd400;

   typedef logic signed [COEF_W-1:0] coef_type;
   typedef coef_type [NUM_COEF-1:0] coef_bank_type;

   typedef enum logic [2:0] {
      REG_DEADBAND = 3'd0,
      REG_SCOUNT   = 3'd1,
      REG_COEF0    = 3'd2,
      REG_COEF1    = 3'd3,
      REG_COEF2    = 3'd4,
      REG_COEF3    = 3'd5,
      REG_COEF4    = 3'd6,
      REG_COEF5    = 3'd7
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_MEAN,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_PROD,
      ST_ADD,
      ST_GROSS,
      ST_NET
   } back_state_type;

endpackage

// ===== rtl/core/fmps_front.sv =====
module fmps_front #(
   parameter int SKIP_COUNT  = 15,
   parameter int COUNT_WIDTH = 12,
   parameter int SUM_W       = 36
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic signed [fmps_pkg::SAMPLE_W-1:0]   in_sample,
   input  logic                                   in_tare,
   input  logic [fmps_pkg::DEADBAND_W-1:0]        deadband,
   input  logic [fmps_pkg::SCOUNT_W-1:0]          sample_count,
   input  logic                                   q_full,
   output logic                                   q_push,
   output logic signed [SUM_W-1:0]                push_sum,
   output logic [COUNT_WIDTH:0]                   push_n,
   output logic                                   push_tare
);
   import fmps_pkg::*;

   localparam int CMP_W = (COUNT_WIDTH + 1 > SCOUNT_W + 1) ? COUNT_WIDTH + 1 : SCOUNT_W + 1;

   logic [3:0]               skip_ff, skip_in;
   logic [COUNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;

   logic                     accept, skipping, pass, done;
   logic [SAMPLE_W-1:0]      absz;
   logic [COUNT_WIDTH:0]     n;
   logic [SCOUNT_W-1:0]      target;
   logic signed [SUM_W-1:0]  sum_next;

   assign in_ready = !q_full;
   assign accept   = in_valid && !q_full;
   assign skipping = skip_ff < 4'(SKIP_COUNT);
   assign absz     = in_sample[SAMPLE_W-1] ? SAMPLE_W'(-in_sample) : SAMPLE_W'(in_sample);
   assign pass     = absz > {1'b0, deadband};
   assign n        = {1'b0, cnt_ff} + (COUNT_WIDTH+1)'(1);
   assign target   = (sample_count == '0) ? SCOUNT_W'(1) : sample_count;
   assign done     = !((CMP_W'(n) < CMP_W'(target)) && !n[COUNT_WIDTH]);
   assign sum_next = sum_ff + $signed({{(SUM_W-SAMPLE_W){in_sample[SAMPLE_W-1]}}, in_sample});

   assign q_push    = accept && !skipping && pass && done;
   assign push_sum  = sum_next;
   assign push_n    = n;
   assign push_tare = in_tare;

   always_comb begin
      skip_in = skip_ff;
      cnt_in  = cnt_ff;
      sum_in  = sum_ff;
      if (accept) begin
         if (skipping) begin
            skip_in = skip_ff + 4'd1;
         end else if (pass) begin
            if (done) begin
               skip_in = '0;
               cnt_in  = '0;
               sum_in  = '0;
            end else begin
               cnt_in = n[COUNT_WIDTH-1:0];
               sum_in = sum_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= '0;
         cnt_ff  <= '0;
         sum_ff  <= '0;
      end else begin
         skip_ff <= skip_in;
         cnt_ff  <= cnt_in;
         sum_ff  <= sum_in;
      end
   end

endmodule

// ===== rtl/core/fmps_queue.sv =====
module fmps_queue #(
   parameter int WIDTH = 50
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);
   import fmps_pkg::*;

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       fill_ff;

   assign full     = fill_ff == 2'd2;
   assign empty    = fill_ff == 2'd0;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         fill_ff <= fill_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

// ===== rtl/core/fmps_back.sv =====
module fmps_back #(
   parameter int COUNT_WIDTH = 12,
   parameter int SUM_W       = 36
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  q_empty,
   output logic                                  q_pop,
   input  logic signed [SUM_W-1:0]               pop_sum,
   input  logic [COUNT_WIDTH:0]                  pop_n,
   input  logic                                  pop_tare,
   input  fmps_pkg::coef_bank_type               coef,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic signed [fmps_pkg::WEIGHT_W-1:0]  out_net,
   output logic signed [fmps_pkg::SAMPLE_W-1:0]  out_mean,
   output logic signed [fmps_pkg::WEIGHT_W-1:0]  out_tare,
   output logic                                  out_sat
);
   import fmps_pkg::*;

   localparam int DW    = SUM_W;
   localparam int BCW   = $clog2(DW + 1);
   localparam int REM_W = COUNT_WIDTH + 2;
   localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};
   localparam logic signed [33:0] S32_MAX = 34'sd2147483647;
   localparam logic signed [33:0] S32_MIN = -34'sd2147483648;

   back_state_type state_ff, state_in;

   logic [DW-1:0]           dvd_ff;
   logic [COUNT_WIDTH:0]    div_n_ff;
   logic [REM_W-1:0]        rem_ff;
   logic [BCW-1:0]          bit_cnt_ff;
   logic                    neg_ff;
   logic                    tare_req_ff;
   logic signed [SAMPLE_W-1:0] mean_ff;
   logic signed [63:0]      acc_ff;
   logic signed [63:0]      prod_ff;
   logic [2:0]              k_ff;
   logic                    sat_ff;
   logic [55:0]             lo_ff, hi_ff;
   logic signed [WEIGHT_W-1:0] gross_ff, tare_ff;
   logic                    out_valid_ff;
   logic signed [WEIGHT_W-1:0] out_net_ff, out_tare_ff;
   logic signed [SAMPLE_W-1:0] out_mean_ff;
   logic                    out_sat_ff;

   logic                    out_space, out_load, div_last;
   logic [DW-1:0]           sum_mag;
   logic [REM_W-1:0]        rem_sh;
   logic                    q_bit;
   logic [SAMPLE_W-1:0]     qm;
   logic [63:0]             am;
   logic [SAMPLE_W-1:0]     bm;
   logic [31:0]             mult_a;
   logic [55:0]             mult_p;
   logic                    pneg;
   logic [64:0]             qsum;
   logic signed [63:0]      prod_val;
   logic                    prod_sat;
   logic signed [64:0]      add_s;
   logic signed [63:0]      add_val;
   logic [64:0]             gr_sum;
   logic [32:0]             gr_r;
   logic signed [33:0]      gr_s;
   logic signed [WEIGHT_W-1:0] gross_val;
   logic signed [32:0]      net_d;
   logic signed [WEIGHT_W-1:0] net_val;
   logic                    net_sat;

   assign out_space = !out_valid_ff || out_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (!q_empty) state_in = ST_DIV;
         ST_DIV:    if (div_last) state_in = ST_MEAN;
         ST_MEAN:   state_in = ST_MUL_LO;
         ST_MUL_LO: state_in = ST_MUL_HI;
         ST_MUL_HI: state_in = ST_PROD;
         ST_PROD:   state_in = ST_ADD;
         ST_ADD:    state_in = (k_ff == 3'd0) ? ST_GROSS : ST_MUL_LO;
         ST_GROSS:  state_in = ST_NET;
         ST_NET:    if (out_space) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      q_pop    = 1'b0;
      out_load = 1'b0;
      case (state_ff)
         ST_IDLE: q_pop    = !q_empty;
         ST_NET:  out_load = out_space;
         default: begin
            q_pop    = 1'b0;
            out_load = 1'b0;
         end
      endcase
   end

   // restoring divider, one quotient bit a cycle
   assign div_last = bit_cnt_ff == BCW'(1);
   assign sum_mag  = pop_sum[SUM_W-1] ? DW'(-pop_sum) : DW'(pop_sum);
   assign rem_sh   = {rem_ff[REM_W-2:0], dvd_ff[DW-1]};
   assign q_bit    = rem_sh >= REM_W'(div_n_ff);
   assign qm       = dvd_ff[SAMPLE_W-1:0];

   // shared 32x24 multiplier, low then high half of the accumulator
   assign am     = acc_ff[63] ? 64'(-acc_ff) : 64'(acc_ff);
   assign bm     = mean_ff[SAMPLE_W-1] ? SAMPLE_W'(-mean_ff) : SAMPLE_W'(mean_ff);
   assign mult_a = (state_ff == ST_MUL_HI) ? am[63:32] : am[31:0];
   assign mult_p = 56'(mult_a) * 56'(bm);

   always_comb begin
      pneg     = (acc_ff[63] != mean_ff[SAMPLE_W-1]) && (am != '0) && (bm != '0);
      qsum     = {2'b0, hi_ff[38:0], 24'b0} + 65'((lo_ff + 56'd128) >> 8);
      prod_sat = 1'b0;
      prod_val = '0;
      if (hi_ff >= 56'h80_0000_0000) begin
         prod_sat = 1'b1;
         prod_val = (acc_ff[63] != mean_ff[SAMPLE_W-1]) ? S64_MIN : S64_MAX;
      end else if (pneg) begin
         if (qsum > 65'h0_8000_0000_0000_0000) begin
            prod_sat = 1'b1;
            prod_val = S64_MIN;
         end else begin
            prod_val = 64'(-qsum);
         end
      end else begin
         if (qsum > 65'h0_7FFF_FFFF_FFFF_FFFF) begin
            prod_sat = 1'b1;
            prod_val = S64_MAX;
         end else begin
            prod_val = qsum[63:0];
         end
      end
   end

   always_comb begin
      add_s   = {prod_ff[63], prod_ff} + {coef[k_ff][63], coef[k_ff]};
      add_val = add_s[63:0];
      if (add_s[64] != add_s[63]) begin
         add_val = add_s[64] ? S64_MIN : S64_MAX;
      end
   end

   always_comb begin
      gr_sum    = {1'b0, am} + 65'h0_8000_0000;
      gr_r      = gr_sum[64:32];
      gr_s      = acc_ff[63] ? -$signed({1'b0, gr_r}) : $signed({1'b0, gr_r});
      gross_val = gr_s[WEIGHT_W-1:0];
      if (gr_s > S32_MAX)      gross_val = S32_MAX[WEIGHT_W-1:0];
      else if (gr_s < S32_MIN) gross_val = S32_MIN[WEIGHT_W-1:0];
   end

   always_comb begin
      net_d   = {gross_ff[WEIGHT_W-1], gross_ff} - {tare_ff[WEIGHT_W-1], tare_ff};
      net_val = net_d[WEIGHT_W-1:0];
      net_sat = net_d[32] != net_d[31];
      if (net_sat) net_val = net_d[32] ? S32_MIN[WEIGHT_W-1:0] : S32_MAX[WEIGHT_W-1:0];
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            dvd_ff      <= sum_mag + DW'(pop_n >> 1);
            div_n_ff    <= pop_n;
            rem_ff      <= '0;
            bit_cnt_ff  <= BCW'(DW);
            neg_ff      <= pop_sum[SUM_W-1];
            tare_req_ff <= pop_tare;
         end
         ST_DIV: begin
            rem_ff     <= q_bit ? rem_sh - REM_W'(div_n_ff) : rem_sh;
            dvd_ff     <= {dvd_ff[DW-2:0], q_bit};
            bit_cnt_ff <= bit_cnt_ff - BCW'(1);
         end
         ST_MEAN: begin
            mean_ff <= neg_ff ? SAMPLE_W'(-qm) : SAMPLE_W'(qm);
            acc_ff  <= coef[5];
            k_ff    <= 3'd4;
            sat_ff  <= 1'b0;
         end
         ST_MUL_LO: lo_ff <= mult_p;
         ST_MUL_HI: hi_ff <= mult_p;
         ST_PROD: begin
            prod_ff <= prod_val;
            if (prod_sat) sat_ff <= 1'b1;
         end
         ST_ADD: begin
            acc_ff <= add_val;
            k_ff   <= k_ff - 3'd1;
            if (add_s[64] != add_s[63]) sat_ff <= 1'b1;
         end
         ST_GROSS: begin
            gross_ff <= gross_val;
            if (gr_s > S32_MAX || gr_s < S32_MIN) sat_ff <= 1'b1;
         end
         default: begin
         end
      endcase
      if (out_load) begin
         out_net_ff  <= net_val;
         out_mean_ff <= mean_ff;
         out_tare_ff <= tare_ff;
         out_sat_ff  <= sat_ff || net_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tare_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load && tare_req_ff) tare_ff <= gross_ff;
         if (out_load)       out_valid_ff <= 1'b1;
         else if (out_ready) out_valid_ff <= 1'b0;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_net   = out_net_ff;
   assign out_mean  = out_mean_ff;
   assign out_tare  = out_tare_ff;
   assign out_sat   = out_sat_ff;

endmodule

// ===== rtl/core/filtered_mean_poly_scale.sv =====
// Block mean with fifth-order polynomial calibration and tare. The front end
// takes one sample transaction every cycle while its two-entry queue has room;
// it discards the warm-up samples, drops samples inside the deadband and sums
// the rest. The completing sample pushes the sum into the queue and the back
// end works it out: a restoring divider producing one quotient bit a cycle
// over 24 + COUNT_WIDTH bits (36 by default), then five Horner steps on one
// shared 32x24 multiplier, each running through the states MUL_LO, MUL_HI,
// PROD and ADD, then gross and net. Samples keep flowing meanwhile; a second
// completing sample may wait in the queue.
module filtered_mean_poly_scale #(
   parameter int SKIP_COUNT  = fmps_pkg::SKIP_COUNT_DEF,
   parameter int COUNT_WIDTH = fmps_pkg::COUNT_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // field_sample[23:0]
   input  logic        req_tuser,   // tare_button
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // net_weight[31:0], mean_field[55:32], tare_used[87:56]
   output logic        rsp_tuser,   // saturated
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import fmps_pkg::*;

   localparam int SUM_W = SAMPLE_W + COUNT_WIDTH;
   localparam int Q_W   = SUM_W + COUNT_WIDTH + 2;

   logic [DEADBAND_W-1:0] deadband_ff;
   logic [SCOUNT_W-1:0]   scount_ff;
   coef_bank_type         coef_ff;
   reg_index_type         csr_idx;
   logic                  csr_wr;

   logic                  q_push, q_pop, q_full, q_empty;
   logic signed [SUM_W-1:0] push_sum, pop_sum;
   logic [COUNT_WIDTH:0]  push_n, pop_n;
   logic                  push_tare, pop_tare;
   logic [Q_W-1:0]        q_rd;

   logic signed [WEIGHT_W-1:0] net_w, tare_w;
   logic signed [SAMPLE_W-1:0] mean_w;

   assign csr_pready = 1'b1;
   assign csr_idx    = reg_index_type'(csr_paddr[5:3]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff <= DEADBAND_RST;
         scount_ff   <= SCOUNT_RST;
         coef_ff     <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_DEADBAND: deadband_ff <= csr_pwdata[DEADBAND_W-1:0];
            REG_SCOUNT:   scount_ff   <= csr_pwdata[SCOUNT_W-1:0];
            REG_COEF0:    coef_ff[0]  <= csr_pwdata;
            REG_COEF1:    coef_ff[1]  <= csr_pwdata;
            REG_COEF2:    coef_ff[2]  <= csr_pwdata;
            REG_COEF3:    coef_ff[3]  <= csr_pwdata;
            REG_COEF4:    coef_ff[4]  <= csr_pwdata;
            REG_COEF5:    coef_ff[5]  <= csr_pwdata;
            default:      deadband_ff <= deadband_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_DEADBAND: csr_prdata = 64'(deadband_ff);
         REG_SCOUNT:   csr_prdata = 64'(scount_ff);
         REG_COEF0:    csr_prdata = coef_ff[0];
         REG_COEF1:    csr_prdata = coef_ff[1];
         REG_COEF2:    csr_prdata = coef_ff[2];
         REG_COEF3:    csr_prdata = coef_ff[3];
         REG_COEF4:    csr_prdata = coef_ff[4];
         REG_COEF5:    csr_prdata = coef_ff[5];
         default:      csr_prdata = '0;
      endcase
   end

   fmps_front #(
      .SKIP_COUNT  (SKIP_COUNT),
      .COUNT_WIDTH (COUNT_WIDTH),
      .SUM_W       (SUM_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_sample    ($signed(req_tdata)),
      .in_tare      (req_tuser),
      .deadband     (deadband_ff),
      .sample_count (scount_ff),
      .q_full       (q_full),
      .q_push       (q_push),
      .push_sum     (push_sum),
      .push_n       (push_n),
      .push_tare    (push_tare)
   );

   fmps_queue #(
      .WIDTH (Q_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({push_tare, push_n, push_sum}),
      .pop       (q_pop),
      .pop_data  (q_rd),
      .full      (q_full),
      .empty     (q_empty)
   );

   assign pop_sum  = $signed(q_rd[SUM_W-1:0]);
   assign pop_n    = q_rd[SUM_W +: COUNT_WIDTH+1];
   assign pop_tare = q_rd[Q_W-1];

   fmps_back #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .SUM_W       (SUM_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .pop_sum   (pop_sum),
      .pop_n     (pop_n),
      .pop_tare  (pop_tare),
      .coef      (coef_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_net   (net_w),
      .out_mean  (mean_w),
      .out_tare  (tare_w),
      .out_sat   (rsp_tuser)
   );

   assign rsp_tdata = {tare_w, mean_w, net_w};

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full) else $error("push into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty) else $error("pop from empty queue");

   a_pop_then_busy: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> !q_pop) else $error("back end popped twice in a row");

endmodule
